// ===== hdl/rsidi_pkg.sv =====
// Package for the random stall / interrupt-defer injector.
// Types, constants and state enum; no dependencies.
`default_nettype none
package rsidi_pkg;
  localparam int          NumCpusDef = 64;
  localparam logic [63:0] Golden     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] OutMul     = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] Million    = 64'd1000000;
  localparam logic [15:0] FoldMul    = 16'd48576;   // 2^20 mod 1e6
  localparam logic [19:0] RateReset  = 20'd100;
  localparam logic [15:0] StallReset = 16'd200;
  localparam logic [7:0]  HoldReset  = 8'd8;

  localparam logic [1:0] RegSeed  = 2'd0;
  localparam logic [1:0] RegRate  = 2'd1;
  localparam logic [1:0] RegStall = 2'd2;
  localparam logic [1:0] RegHold  = 2'd3;

  localparam logic OpStall = 1'b0;
  localparam logic OpIrq   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_XS1, S_XS2, S_XS3, S_MUL, S_FOLD, S_SUB, S_DIV,
    S_RES, S_WB
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/rsidi_if.sv =====
// Valid/ready word channel interfaces for the injector.
// Depends on nothing.
`default_nettype none
interface rsidi_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [5:0] cpu;
  modport source (output valid, output op, output cpu, input ready);
  modport sink (input valid, input op, input cpu, output ready);
endinterface

interface rsidi_out_if;
  logic        valid;
  logic        ready;
  logic        stall_res;
  logic [15:0] stall_length;
  logic        defer;
  modport source (output valid, output stall_res, output stall_length, output defer,
                  input ready);
  modport sink (input valid, input stall_res, input stall_length, input defer,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/random_stall_and_irq_defer_injector.sv =====
// Top level of the random stall / interrupt-defer injector.
// Depends on rsidi_pkg and the channel interfaces in rsidi_if.sv.
`default_nettype none
// One word in, one word out. Each CPU owns a xorshift64* generator that is
// seeded on its first request. Every word runs through one shared 64x16
// multiplier under a small sequencer: it forms golden*(cpu+1) for seeding,
// does the 64x64 output multiply as four 16-bit slices, and folds the draw
// for the mod-1e6 (2^20 = 48576 mod 1e6, at most ten folds plus an exit
// check, then at most two subtracts plus the decision cycle). The variable
// modulos (stall length, hold count) use a restoring divider, one bit a
// cycle, on the 48 bits of r>>16 for a stall and on all 64 bits of the
// second draw for a hold. A word for a CPU beyond NUM_CPUS skips the draw.
// A stall word draws once and divides only when it stalls; an interrupt
// word skips the draw when a hold is pending, else draws once, and twice
// when a hold starts. The input is not ready while a word is in flight or
// a result waits, so the next word is taken in the cycle after the result
// is taken at the earliest. Generator and hold count share one per-CPU
// memory that is never cleared; the per-CPU seeded flags reset to zero and
// mark an entry valid, and an unseeded CPU reads a hold count of zero.
module random_stall_and_irq_defer_injector #(
  parameter int NUM_CPUS = rsidi_pkg::NumCpusDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsidi_in_if.sink         in_ch,
  rsidi_out_if.source      out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);
  import rsidi_pkg::*;
  localparam int IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  logic [63:0] seed_r;
  logic [19:0] rate_r;
  logic [15:0] max_stall_r;
  logic [7:0]  max_hold_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // per-CPU state: {hold count, generator}
  logic [71:0]         cpu_mem [NUM_CPUS];
  logic [71:0]         rd_r;
  logic [NUM_CPUS-1:0] seeded_r;

  state_t state_r, state_nxt;
  logic          op_r;
  logic [IW-1:0] cpu_r;
  logic          in_range_r;
  logic          second_r;   // second draw of an interrupt hold
  logic [63:0]   x_r;        // generator working value
  logic [63:0]   acc_r;      // product / fold value / dividend shift register
  logic [47:0]   r_hi_r;     // drawn value >> 16
  logic [15:0]   rem_r;      // divider remainder
  logic [15:0]   div_r;      // divider divisor
  logic [6:0]    cnt_r;
  logic [7:0]    hold_w_r;   // hold count written back
  logic          stall_q_r, defer_q_r;
  logic [15:0]   len_q_r;
  logic          ovalid_r;

  logic        in_acc;
  logic [7:0]  hold_cur;
  logic [15:0] cpu_p1;
  logic [63:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] pp;
  logic [63:0] acc_sum;
  logic [63:0] seed_val;
  logic [15:0] m_stall, m_hold;
  logic [26:0] rate_x100;
  logic        draw_hit;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [15:0] rem_nxt;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 64'd1;
      rate_r      <= RateReset;
      max_stall_r <= StallReset;
      max_hold_r  <= HoldReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegSeed:  seed_r      <= cfg_pwdata;
        RegRate:  rate_r      <= cfg_pwdata[19:0];
        RegStall: max_stall_r <= cfg_pwdata[15:0];
        RegHold:  max_hold_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSeed:  cfg_prdata = seed_r;
      RegRate:  cfg_prdata = {44'd0, rate_r};
      RegStall: cfg_prdata = {48'd0, max_stall_r};
      RegHold:  cfg_prdata = {56'd0, max_hold_r};
      default:  cfg_prdata = 64'd0;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  // an unseeded CPU has no hold pending
  assign hold_cur    = seeded_r[cpu_r] ? rd_r[71:64] : 8'd0;
  assign cpu_p1      = 16'(cpu_r) + 16'd1;
  assign m_stall     = (max_stall_r == 16'd0) ? 16'd1 : max_stall_r;
  assign m_hold      = {8'd0, (max_hold_r == 8'd0) ? 8'd1 : max_hold_r};
  // rate * 100 = rate * (64 + 32 + 4)
  assign rate_x100   = 27'({rate_r, 6'd0}) + 27'({rate_r, 5'd0}) + 27'({rate_r, 2'd0});

  // shared 64x16 multiplier
  always_comb begin
    mul_a = 64'd0;
    mul_b = 16'd0;
    case (state_r)
      S_LOAD: begin
        mul_a = Golden;
        mul_b = cpu_p1;
      end
      S_MUL: begin
        mul_a = x_r;
        mul_b = OutMul[{cnt_r[1:0], 4'd0} +: 16];
      end
      S_FOLD: begin
        mul_a = {20'd0, acc_r[63:20]};
        mul_b = FoldMul;
      end
      default: ;
    endcase
  end
  assign pp       = mul_a * {48'd0, mul_b};
  assign acc_sum  = acc_r + (pp << {cnt_r[1:0], 4'd0});
  assign seed_val = (seed_r ^ pp) | 64'd1;

  // acc_r holds draw mod 1e6 once S_SUB stops subtracting
  assign draw_hit = (op_r == OpStall) ? (acc_r < {44'd0, rate_r})
                                      : (acc_r < {37'd0, rate_x100});

  assign rem_sh  = {rem_r, acc_r[63]};
  assign rem_ge  = rem_sh >= {1'b0, div_r};
  assign rem_nxt = rem_ge ? 16'(rem_sh - {1'b0, div_r}) : rem_sh[15:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LOAD;
      S_LOAD: begin
        if (!in_range_r) state_nxt = S_WB;
        else if (op_r == OpIrq && hold_cur != 8'd0) state_nxt = S_WB;
        else state_nxt = S_XS1;
      end
      S_XS1: state_nxt = S_XS2;
      S_XS2: state_nxt = S_XS3;
      S_XS3: state_nxt = S_MUL;
      S_MUL: if (cnt_r[1:0] == 2'd3) state_nxt = second_r ? S_DIV : S_FOLD;
      S_FOLD: if (acc_r[63:21] == 43'd0) state_nxt = S_SUB;
      S_SUB: begin
        if (acc_r < Million) begin
          if (!draw_hit) state_nxt = S_WB;
          else if (op_r == OpStall) state_nxt = S_DIV;
          else state_nxt = S_XS1;
        end
      end
      S_DIV: if (cnt_r == 7'd0) state_nxt = S_RES;
      S_RES: state_nxt = S_WB;
      S_WB: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      seeded_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_acc) begin
          op_r       <= in_ch.op;
          cpu_r      <= IW'(in_ch.cpu);
          in_range_r <= ({26'd0, in_ch.cpu} < NUM_CPUS);
          second_r   <= 1'b0;
          stall_q_r  <= 1'b0;
          defer_q_r  <= 1'b0;
          len_q_r    <= 16'd0;
        end
        S_LOAD: begin
          x_r <= seeded_r[cpu_r] ? rd_r[63:0] : seed_val;
          if (op_r == OpIrq && hold_cur != 8'd0) begin
            hold_w_r  <= hold_cur - 8'd1;
            defer_q_r <= 1'b1;
          end else begin
            hold_w_r <= hold_cur;
          end
        end
        S_XS1: x_r <= x_r ^ (x_r >> 12);
        S_XS2: x_r <= x_r ^ (x_r << 25);
        S_XS3: begin
          x_r   <= x_r ^ (x_r >> 27);
          acc_r <= 64'd0;
          cnt_r <= 7'd0;
        end
        S_MUL: begin
          acc_r <= acc_sum;
          if (cnt_r[1:0] == 2'd3) begin
            r_hi_r <= acc_sum[63:16];
            rem_r  <= 16'd0;
            div_r  <= m_hold;
            cnt_r  <= second_r ? 7'd63 : 7'd0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_FOLD: if (acc_r[63:21] != 43'd0) acc_r <= pp + {44'd0, acc_r[19:0]};
        S_SUB: begin
          if (acc_r >= Million) begin
            acc_r <= acc_r - Million;
          end else if (draw_hit) begin
            if (op_r == OpStall) begin
              acc_r <= {r_hi_r, 16'd0};
              rem_r <= 16'd0;
              div_r <= m_stall;
              cnt_r <= 7'd47;
            end else begin
              second_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          acc_r <= {acc_r[62:0], 1'b0};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 7'd1;
        end
        S_RES: begin
          if (op_r == OpStall) begin
            stall_q_r <= 1'b1;
            len_q_r   <= rem_r + 16'd1;
          end else begin
            defer_q_r <= 1'b1;
            hold_w_r  <= 8'(rem_r) + 8'd1;
          end
        end
        S_WB: begin
          if (in_range_r) seeded_r[cpu_r] <= 1'b1;
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // per-CPU memory: registered read at accept, one write per word for a CPU in range
  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= cpu_mem[IW'(in_ch.cpu)];
    if (state_r == S_WB && in_range_r) cpu_mem[cpu_r] <= {hold_w_r, x_r};
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.stall_res    = stall_q_r;
  assign out_ch.stall_length = len_q_r;
  assign out_ch.defer        = defer_q_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.defer && out_ch.stall_res)) else $error("both results");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.stall_res) |-> (out_ch.stall_length == 16'd0))
    else $error("length without stall");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the random stall / interrupt-defer injector.
// Depends on rsidi_pkg, the channel interfaces in rsidi_if.sv and the top level.
// A per-CPU xorshift64* predictor checks every result word in order.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsidi_pkg::*;

  localparam int NCpu = 64;
  localparam int StallLimit = 2000; // cycles without any accepted word

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  rsidi_in_if  in_ch ();
  rsidi_out_if out_ch ();

  random_stall_and_irq_defer_injector dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct packed {
    logic        stall_res;
    logic [15:0] stall_length;
    logic        defer;
  } verdict_t;

  // Predictor copy of the block's configuration and per-CPU state.
  logic [63:0] seed_q;
  logic [19:0] rate_q;
  logic [15:0] max_stall_q;
  logic [7:0]  max_hold_q;
  logic [63:0] gen_q   [NCpu];
  logic [7:0]  hold_q  [NCpu];
  bit          seeded_q[NCpu];

  verdict_t pending_verdicts[$];
  int  errors;
  int  idle_cycles;
  bit  watchdog_fired;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] next_draw(int c);
    logic [63:0] x;
    x = gen_q[c];
    x ^= x >> 12;
    x ^= x << 25;
    x ^= x >> 27;
    gen_q[c] = x;
    return x * OutMul;
  endfunction

  function automatic verdict_t predict_verdict(logic op, logic [5:0] cpu);
    verdict_t v;
    logic [63:0] r, m;
    int c;
    v = '0;
    c = cpu;
    if (!seeded_q[c]) begin
      gen_q[c] = (seed_q ^ (Golden * 64'(c + 1))) | 64'd1;
      seeded_q[c] = 1'b1;
    end
    if (op == OpStall) begin
      r = next_draw(c);
      if ((r % Million) < 64'(rate_q)) begin
        m = (max_stall_q == 0) ? 64'd1 : 64'(max_stall_q);
        v.stall_res = 1'b1;
        v.stall_length = 16'(64'd1 + ((r >> 16) % m));
      end
    end else if (hold_q[c] != 0) begin
      hold_q[c] = hold_q[c] - 8'd1;
      v.defer = 1'b1;
    end else if ((next_draw(c) % Million) < 64'(rate_q) * 64'd100) begin
      m = (max_hold_q == 0) ? 64'd1 : 64'(max_hold_q);
      hold_q[c] = 8'(64'd1 + (next_draw(c) % m));
      v.defer = 1'b1;
    end
    return v;
  endfunction

  // APB write: setup cycle, then access cycle; register lands at 8*index.
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      RegSeed:  seed_q      = value;
      RegRate:  rate_q      = value[19:0];
      RegStall: max_stall_q = value[15:0];
      default:  max_hold_q  = value[7:0];
    endcase
  endtask

  // Sends one word with a random lead-in gap; prediction at acceptance.
  // valid stays up on return; the next send or drain() takes it down.
  task automatic send_word(logic op, logic [5:0] cpu);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0; // runs without gaps
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.cpu   <= cpu;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(op, cpu));
    @(negedge clk);
  endtask

  // Block is idle once every result is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic test_directed();
    int c;
    // Reset config: first touch of each CPU extreme, both ops.
    send_word(OpStall, 6'd0);
    send_word(OpIrq,   6'd0);
    send_word(OpStall, 6'd63);
    send_word(OpIrq,   6'd63);
    drain();
    // Rate above a million: always stall / always hold, lengths at extremes.
    write_reg(RegRate, 64'hFFFFF);
    write_reg(RegStall, 64'd0);      // acts as 1
    write_reg(RegHold, 64'd0);
    send_word(OpStall, 6'd21);
    send_word(OpIrq,   6'd21);
    send_word(OpIrq,   6'd21);
    drain();
    write_reg(RegStall, 64'd65535);
    write_reg(RegHold, 64'd255);
    write_reg(RegSeed, 64'hFFFF_FFFF_FFFF_FFFF);
    for (c = 0; c < 6; c++) send_word(OpIrq, 6'(42 + c));
    send_word(OpStall, 6'd42);
    send_word(OpStall, 6'd47);
    drain();
    // Rate zero: never stall, never start a hold.
    write_reg(RegRate, 64'd0);
    send_word(OpStall, 6'd5);
    send_word(OpIrq,   6'd5);
    send_word(OpIrq,   6'd42);   // pending hold still counts down
    drain();
  endtask

  // Random words under one configuration; CPUs sometimes clustered.
  task automatic test_random(int n, logic [19:0] rate, logic [15:0] ms,
                             logic [7:0] mh);
    int i;
    logic [5:0] cpu;
    write_reg(RegRate, 64'(rate));
    write_reg(RegStall, 64'(ms));
    write_reg(RegHold, 64'(mh));
    for (i = 0; i < n; i++) begin
      cpu = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
      send_word(1'($urandom), cpu);
    end
    drain();
  endtask

  // Sender holds off until every result is in, then resumes.
  task automatic test_hold_off();
    int i;
    for (i = 0; i < 8; i++) send_word(1'($urandom), 6'($urandom));
    drain();
    for (i = 0; i < 8; i++) send_word(1'($urandom), 6'($urandom));
    drain();
  endtask

  // Result sink: random back-pressure, checks each word against the queue.
  initial begin
    int gap;
    verdict_t exp_v;
    out_ch.ready = 1'b0;
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && rst_n)) @(posedge clk);
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected word: stall=%0b len=%0d defer=%0b", $time,
                 out_ch.stall_res, out_ch.stall_length, out_ch.defer);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_ch.stall_res !== exp_v.stall_res) begin
          $display("%0t stall_res exp %0b got %0b", $time, exp_v.stall_res,
                   out_ch.stall_res);
          errors++;
        end
        if (out_ch.stall_length !== exp_v.stall_length) begin
          $display("%0t stall_length exp %0d got %0d", $time, exp_v.stall_length,
                   out_ch.stall_length);
          errors++;
        end
        if (out_ch.defer !== exp_v.defer) begin
          $display("%0t defer exp %0b got %0b", $time, exp_v.defer, out_ch.defer);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: counts cycles with no word accepted on either side.
  initial begin
    idle_cycles = 0;
    watchdog_fired = 1'b0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit && !watchdog_fired) begin
        watchdog_fired = 1'b1;
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int c;
    errors = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.op = 1'b0; in_ch.cpu = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    seed_q = 64'd1; rate_q = RateReset; max_stall_q = StallReset; max_hold_q = HoldReset;
    for (c = 0; c < NCpu; c++) begin
      gen_q[c] = '0; hold_q[c] = '0; seeded_q[c] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    // Rates chosen so stalls and holds show up often enough to check lengths.
    test_random(400, 20'd500000, 16'd1, 8'd1);
    test_random(400, 20'd300000, 16'($urandom_range(2, 65535)),
                8'($urandom_range(2, 255)));
    write_reg(RegSeed, {$urandom, $urandom}); // only reseeds CPUs not yet touched
    test_random(350, 20'd1000000, 16'd65535, 8'd3);
    test_hold_off();
    test_random(330, 20'd5000, 16'd200, 8'd8);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
